[hw/rtl/osc_pkg.sv]
// ----------------------------------------------------------------------------
// osc_pkg: shared types and constants for the obstacle collision checker
// Operation codes, command and response structs, table sizes.
// ----------------------------------------------------------------------------
package osc_pkg;

	localparam int MAX_OBSTACLES = 64;
	localparam int COORD_WIDTH   = 16;

	localparam int FIELD_W   = 16;
	localparam int RAD_W     = 15;
	localparam int SLOT_W    = 6;
	localparam int COUNT_W   = 7;
	localparam int CW        = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
	localparam int IDX_W     = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
	localparam int CNT_W     = $clog2(MAX_OBSTACLES + 1);
	localparam int PIPE_DEPTH = 7;
	localparam int DRAIN_W   = $clog2(PIPE_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_SEG    = 2'd2,
		OP_POINT  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic [1:0]               operation;
		logic signed [FIELD_W-1:0] first_x;
		logic signed [FIELD_W-1:0] first_y;
		logic signed [FIELD_W-1:0] second_x;
		logic signed [FIELD_W-1:0] second_y;
		logic [RAD_W-1:0]         obstacle_radius_in;
	} cmd_t;

	typedef struct packed {
		logic               status;
		logic               path_free;
		logic [SLOT_W-1:0]  hit_slot;
		logic [COUNT_W-1:0] stored_count;
	} rsp_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] cx;
		logic signed [FIELD_W-1:0] cy;
		logic [RAD_W-1:0]          r;
	} obst_t;

	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] idx;
	} feed_t;

	typedef struct packed {
		logic             vld;
		logic             hit;
		logic [IDX_W-1:0] idx;
	} geo_res_t;

	// keep the low CW bits and sign-extend back to the field width
	function automatic logic signed [FIELD_W-1:0] coord_of(input logic [FIELD_W-1:0] raw);
		logic [FIELD_W-1:0] v;
		v = raw;
		for (int b = CW; b < FIELD_W; b++) begin
			v[b] = raw[CW-1];
		end
		return $signed(v);
	endfunction

endpackage

[hw/rtl/osc_cell.sv]
// ----------------------------------------------------------------------------
// osc_cell: one obstacle slot of the rotating table
// Loads an appended obstacle or takes its neighbor's obstacle on a shift.
// ----------------------------------------------------------------------------
module osc_cell (
	input  logic          clk,
	input  logic          load,
	input  logic          shift,
	input  osc_pkg::obst_t load_data,
	input  osc_pkg::obst_t nbr,
	output osc_pkg::obst_t held
);
	import osc_pkg::*;

	obst_t held_q;

	always_ff @(posedge clk) begin
		if (load) begin
			held_q <= load_data;
		end else if (shift) begin
			held_q <= nbr;
		end
	end

	assign held = held_q;

endmodule

[hw/rtl/osc_geom.sv]
// ----------------------------------------------------------------------------
// osc_geom: pipelined segment / point versus circle test
// Seven stages; one obstacle enters per cycle.
// ----------------------------------------------------------------------------
module osc_geom (
	input  logic             clk,
	input  logic             arst_n,
	input  osc_pkg::cmd_t    qry,
	input  osc_pkg::obst_t   obst,
	input  osc_pkg::feed_t   feed,
	output osc_pkg::geo_res_t res
);
	import osc_pkg::*;

	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] idx;
		logic             seg;
		logic             a_zero;
		logic             sc;
		logic             c_neg;
		logic             vert;
		logic             c_le0;
	} flg_t;

	flg_t f_s1, f_s2, f_s3, f_s4, f_s5, f_s6;
	geo_res_t res_s7;

	logic signed [16:0] fx_s1, fy_s1, dx_s1, dy_s1;
	logic [RAD_W-1:0]   r_s1;

	logic signed [33:0] m_fxdx_s2, m_fydy_s2, m_fxfx_s2, m_fyfy_s2;
	logic signed [33:0] m_fxdy_s2, m_fydx_s2, m_dxdx_s2, m_dydy_s2;
	logic [29:0]        rr_s2;

	logic signed [35:0] a_s3, h_s3, c_s3, cr_s3;
	logic [29:0]        rr_s3;
	logic signed [35:0] neg_h;
	logic signed [37:0] g1;

	logic a_zero, c_neg, c_le0, sc, vert, hit;

	logic [34:0] acr_s4, au_s4;
	logic [29:0] rr_s4;

	logic [33:0] p_hh_s5;
	logic [34:0] p_hl_s5;
	logic [35:0] p_ll_s5;
	logic [46:0] q_h_s5;
	logic [47:0] q_l_s5;

	logic [71:0] sq_s6, pr_s6;

	logic signed [FIELD_W-1:0] x1, y1, x2, y2;

	function automatic logic [34:0] neg_cr(input logic signed [35:0] v);
		logic signed [35:0] n;
		n = -v;
		return n[34:0];
	endfunction

	assign x1 = coord_of(qry.first_x);
	assign y1 = coord_of(qry.first_y);
	assign x2 = coord_of(qry.second_x);
	assign y2 = coord_of(qry.second_y);

	assign neg_h = -h_s3;
	assign g1    = 38'(a_s3) + (38'(h_s3) <<< 1) + 38'(c_s3);

	assign a_zero = (a_s3 == '0);
	assign c_neg  = c_s3[35];
	assign c_le0  = c_s3[35] || (c_s3 == '0);
	assign sc     = ((c_s3[35] || c_s3 == '0) && !g1[37])
		|| (!c_s3[35] && (g1[37] || g1 == '0));
	assign vert   = (h_s3[35] || h_s3 == '0) && (neg_h <= a_s3);
	assign hit    = f_s6.seg
		? (!f_s6.a_zero && (f_s6.sc
			|| (!f_s6.c_neg && f_s6.vert && (sq_s6 <= pr_s6))))
		: f_s6.c_le0;

	// control flags carry reset, payload does not
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_s1   <= '0;
			f_s2   <= '0;
			f_s3   <= '0;
			f_s4   <= '0;
			f_s5   <= '0;
			f_s6   <= '0;
			res_s7 <= '0;
		end else begin
			f_s1   <= {feed.vld, feed.idx, (qry.operation == OP_SEG), 5'b0};
			f_s2   <= f_s1;
			f_s3   <= f_s2;
			f_s4   <= {f_s3.vld, f_s3.idx, f_s3.seg, a_zero, sc, c_neg, vert, c_le0};
			f_s5   <= f_s4;
			f_s6   <= f_s5;
			res_s7 <= {f_s6.vld, hit, f_s6.idx};
		end
	end

	always_ff @(posedge clk) begin
		fx_s1 <= {x1[FIELD_W-1], x1} - {obst.cx[FIELD_W-1], obst.cx};
		fy_s1 <= {y1[FIELD_W-1], y1} - {obst.cy[FIELD_W-1], obst.cy};
		dx_s1 <= {x2[FIELD_W-1], x2} - {x1[FIELD_W-1], x1};
		dy_s1 <= {y2[FIELD_W-1], y2} - {y1[FIELD_W-1], y1};
		r_s1  <= obst.r;

		m_fxdx_s2 <= fx_s1 * dx_s1;
		m_fydy_s2 <= fy_s1 * dy_s1;
		m_fxfx_s2 <= fx_s1 * fx_s1;
		m_fyfy_s2 <= fy_s1 * fy_s1;
		m_fxdy_s2 <= fx_s1 * dy_s1;
		m_fydx_s2 <= fy_s1 * dx_s1;
		m_dxdx_s2 <= dx_s1 * dx_s1;
		m_dydy_s2 <= dy_s1 * dy_s1;
		rr_s2     <= r_s1 * r_s1;

		a_s3  <= 36'(m_dxdx_s2) + 36'(m_dydy_s2);
		h_s3  <= 36'(m_fxdx_s2) + 36'(m_fydy_s2);
		c_s3  <= 36'(m_fxfx_s2) + 36'(m_fyfy_s2) - $signed({6'b0, rr_s2});
		cr_s3 <= 36'(m_fxdy_s2) - 36'(m_fydx_s2);
		rr_s3 <= rr_s2;

		acr_s4 <= cr_s3[35] ? neg_cr(cr_s3) : cr_s3[34:0];
		au_s4  <= a_s3[34:0];
		rr_s4  <= rr_s3;

		// split the 35-bit operands into 17 + 18 bit halves
		p_hh_s5 <= acr_s4[34:18] * acr_s4[34:18];
		p_hl_s5 <= 35'(acr_s4[34:18] * acr_s4[17:0]);
		p_ll_s5 <= acr_s4[17:0] * acr_s4[17:0];
		q_h_s5  <= au_s4[34:18] * rr_s4;
		q_l_s5  <= au_s4[17:0] * rr_s4;

		sq_s6 <= (72'(p_hh_s5) << 36) + (72'(p_hl_s5) << 19) + 72'(p_ll_s5);
		pr_s6 <= (72'(q_h_s5) << 18) + 72'(q_l_s5);
	end

	assign res = res_s7;

endmodule

[hw/rtl/obstacle_segment_collision_check.sv]
// ----------------------------------------------------------------------------
// obstacle_segment_collision_check: circle obstacle table with hit queries
// Clear, append, segment query and point query on a table of circles.
// ----------------------------------------------------------------------------
// Pulse start with a command while busy is low; the command transfers on that
// edge. Clear and append answer on done in the very next cycle and leave busy
// low. A segment or point query raises busy and answers once the ring has
// turned and the pipeline has drained, whatever the fill level: the table
// is a ring of cells that rotates once all the way round, streaming one
// obstacle per cycle into a seven-stage geometry pipeline, so the ring
// length plus pipeline depth sets when it answers. done is high for
// exactly one cycle with rsp valid; the receiver cannot stall it, so capture
// it when it shows. Appends on a full table report status 1 and are dropped.
// Slots that were never appended are never tested.
module obstacle_segment_collision_check (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  osc_pkg::cmd_t  cmd,
	output logic           done,
	output osc_pkg::rsp_t  rsp
);
	import osc_pkg::*;

	state_t state_q, state_d;

	cmd_t               cmd_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   step_q;
	logic [DRAIN_W-1:0] drain_q;
	logic               found_q;
	logic [IDX_W-1:0]   slot_q;
	logic               done_q;
	rsp_t               rsp_q;

	logic     accept;
	logic     full;
	logic     is_query;
	logic     do_append;
	logic     shift;
	obst_t    new_obst;
	obst_t    ring [MAX_OBSTACLES];
	feed_t    feed;
	geo_res_t geo;

	assign accept    = start && !busy;
	assign full      = (count_q >= CNT_W'(MAX_OBSTACLES));
	assign is_query  = (cmd.operation == OP_SEG) || (cmd.operation == OP_POINT);
	assign do_append = accept && (cmd.operation == OP_APPEND) && !full;
	assign shift     = (state_q == ST_SCAN);

	assign new_obst.cx = coord_of(cmd.first_x);
	assign new_obst.cy = coord_of(cmd.first_y);
	assign new_obst.r  = cmd.obstacle_radius_in;

	// Ring of slots: each cell hands its obstacle to the one below; slot 0 is
	// the head that feeds the geometry pipeline.
	for (genvar i = 0; i < MAX_OBSTACLES; i++) begin : g_cell
		osc_cell u_cell (
			.clk       (clk),
			.load      (do_append && (count_q[IDX_W-1:0] == IDX_W'(i))),
			.shift     (shift),
			.load_data (new_obst),
			.nbr       (ring[(i + 1) % MAX_OBSTACLES]),
			.held      (ring[i])
		);
	end

	// Feed only slots below the fill level; the rest rotate past unseen.
	assign feed.vld = shift && (CNT_W'(step_q) < count_q);
	assign feed.idx = step_q;

	osc_geom u_geom (
		.clk    (clk),
		.arst_n (arst_n),
		.qry    (cmd_q),
		.obst   (ring[0]),
		.feed   (feed),
		.res    (geo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (accept && is_query) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// one full turn restores the ring order
				if (step_q == IDX_W'(MAX_OBSTACLES - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drain_q == DRAIN_W'(PIPE_DEPTH)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			step_q  <= '0;
			drain_q <= '0;
			found_q <= 1'b0;
			slot_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			// clear and append answer at once, queries at the end of the drain
			done_q <= (accept && ((cmd.operation == OP_CLEAR)
					|| (cmd.operation == OP_APPEND)))
				|| (state_q == ST_DRAIN && drain_q == DRAIN_W'(PIPE_DEPTH));
			if (accept) begin
				step_q  <= '0;
				drain_q <= '0;
				found_q <= 1'b0;
				slot_q  <= '0;
				unique case (op_t'(cmd.operation))
					OP_CLEAR: begin
						count_q <= '0;
					end
					OP_APPEND: begin
						if (!full) begin
							count_q <= count_q + 1'b1;
						end
					end
					OP_SEG, OP_POINT: ;
					default: ;
				endcase
			end
			if (state_q == ST_SCAN) begin
				step_q <= step_q + 1'b1;
			end
			if (state_q == ST_DRAIN) begin
				drain_q <= drain_q + 1'b1;
			end
			// slots arrive in ascending order: keep the first hit only
			if (geo.vld && geo.hit && !found_q) begin
				found_q <= 1'b1;
				slot_q  <= geo.idx;
			end
		end
	end

	// Response payload: hold the query, build the answer without reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			rsp_q <= '{
				status:       (cmd.operation == OP_APPEND) && full,
				path_free:    1'b1,
				hit_slot:     '0,
				stored_count: (cmd.operation == OP_CLEAR) ? '0
					: ((cmd.operation == OP_APPEND) && !full) ? COUNT_W'(count_q + 1'b1)
					: COUNT_W'(count_q)
			};
		end else if (state_q == ST_DRAIN && drain_q == DRAIN_W'(PIPE_DEPTH)) begin
			rsp_q <= '{
				status:       1'b0,
				path_free:    !found_q,
				hit_slot:     SLOT_W'(slot_q),
				stored_count: COUNT_W'(count_q)
			};
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

[hw/rtl/osc_checker.sv]
// ----------------------------------------------------------------------------
// osc_checker: port-level checks for the obstacle collision checker
// Response consistency and busy behavior, bound to the top level.
// ----------------------------------------------------------------------------
module osc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input osc_pkg::cmd_t cmd,
	input logic          done,
	input osc_pkg::rsp_t rsp
);
	import osc_pkg::*;

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd.operation == OP_SEG || cmd.operation == OP_POINT)
		|=> busy && !done)
		else $error("query transfer did not raise busy");

	a_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.path_free |-> rsp.hit_slot == '0)
		else $error("free path with nonzero hit slot");

	a_drop_free: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status |-> rsp.path_free
			&& rsp.stored_count == COUNT_W'(MAX_OBSTACLES))
		else $error("dropped append with inconsistent response");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.stored_count <= COUNT_W'(MAX_OBSTACLES))
		else $error("stored count beyond capacity");

	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy && done |-> 1'b0)
		else $error("response shown while busy");

endmodule

bind obstacle_segment_collision_check osc_checker u_osc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.rsp    (rsp)
);
